// File: sv/aim_pkg.sv
// ----------------------------------------------------------------------------
// aim_pkg
// Shared types and constants for the inverse affine frame-store mapper.
// ----------------------------------------------------------------------------
package aim_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int COEF_W     = 12;
    localparam int SHIFT_W    = 17;
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = 11;
    localparam int PIX_W      = 24;
    localparam int DIM_W      = 12;   // effective size, up to 2048
    localparam int OUTSZ_W    = 17;   // signed scaled output size
    localparam int PROD_W     = 24;   // coef * coord
    localparam int DET_W      = 25;
    localparam int TDET_W     = 42;   // shift * det
    localparam int NUM_W      = 44;   // signed numerator
    localparam int MAG_W      = 48;   // divider datapath
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int IQ_DEPTH   = 4;
    localparam int OQ_DEPTH   = 32;

    localparam logic [COEF_W-1:0]  COEF_ONE_RST = 12'd256;
    localparam logic [COEF_W-1:0]  COEF_ZER_RST = 12'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_X_RST  = 17'd7680;     // +30 px
    localparam logic [SHIFT_W-1:0] SHIFT_Y_RST  = 17'd123392;   // -30 px
    localparam logic [SIZE_W-1:0]  SIZE_RST     = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A     = 3'd0,
        REG_COEF_B     = 3'd1,
        REG_COEF_C     = 3'd2,
        REG_COEF_D     = 3'd3,
        REG_SHIFT_X    = 3'd4,
        REG_SHIFT_Y    = 3'd5,
        REG_SRC_WIDTH  = 3'd6,
        REG_SRC_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_t;

    typedef struct packed {
        logic [COEF_W-1:0]  a;
        logic [COEF_W-1:0]  b;
        logic [COEF_W-1:0]  c;
        logic [COEF_W-1:0]  d;
        logic [SHIFT_W-1:0] tx;
        logic [SHIFT_W-1:0] ty;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } cfg_t;

    typedef struct packed {
        logic               wr;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             io_ok;
        logic             hit;
        logic             sing;
    } result_t;

endpackage

// File: sv/affine_inverse_map_nearest.sv
// ----------------------------------------------------------------------------
// affine_inverse_map_nearest
// Frame store with inverse affine warp and nearest-neighbor lookup.
//
// Sustains one request per clock unless the input queue is full or reads
// wait on result-queue credit: writes store a pixel, reads map the output
// coordinate back through the inverse matrix and return one result each.
// A read passes the S1-S3 stages, the per-bit divider pipeline and the
// single frame-store port before its result is queued. The store is not
// cleared at reset; reading a location never written returns arbitrary data.
// ----------------------------------------------------------------------------
module affine_inverse_map_nearest #(
    parameter int MAX_WIDTH  = aim_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = aim_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [aim_pkg::COORD_W-1:0]    s_col,
    input  logic [aim_pkg::COORD_W-1:0]    s_row,
    input  logic [aim_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [aim_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                           m_in_output,
    output logic                           m_source_hit,
    output logic                           m_singular,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aim_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aim_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.a  <= COEF_ONE_RST;
            cfg_reg.b  <= COEF_ZER_RST;
            cfg_reg.c  <= COEF_ZER_RST;
            cfg_reg.d  <= COEF_ONE_RST;
            cfg_reg.tx <= SHIFT_X_RST;
            cfg_reg.ty <= SHIFT_Y_RST;
            cfg_reg.w  <= SIZE_RST;
            cfg_reg.h  <= SIZE_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_COEF_A:     cfg_reg.a  <= cfg_data[COEF_W-1:0];
                REG_COEF_B:     cfg_reg.b  <= cfg_data[COEF_W-1:0];
                REG_COEF_C:     cfg_reg.c  <= cfg_data[COEF_W-1:0];
                REG_COEF_D:     cfg_reg.d  <= cfg_data[COEF_W-1:0];
                REG_SHIFT_X:    cfg_reg.tx <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y:    cfg_reg.ty <= cfg_data[SHIFT_W-1:0];
                REG_SRC_WIDTH:  cfg_reg.w  <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: cfg_reg.h  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic  iq_push, iq_pop, iq_empty, iq_full;
    item_t iq_in, iq_head;

    aim_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_col      (s_col),
        .s_row      (s_row),
        .s_pixel_in (s_pixel_in),
        .q_full     (iq_full),
        .q_push     (iq_push),
        .q_item     (iq_in)
    );

    aim_fifo #(.WIDTH($bits(item_t)), .DEPTH(IQ_DEPTH)) u_iq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (iq_push),
        .push_data (iq_in),
        .pop       (iq_pop),
        .head      (iq_head),
        .empty     (iq_empty),
        .full      (iq_full)
    );

    aim_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_head       (iq_head),
        .q_empty      (iq_empty),
        .q_pop        (iq_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_in_output  (m_in_output),
        .m_source_hit (m_source_hit),
        .m_singular   (m_singular)
    );

endmodule

// File: sv/aim_fifo.sv
// ----------------------------------------------------------------------------
// aim_fifo
// Small show-ahead FIFO built from registers.
// ----------------------------------------------------------------------------
module aim_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(DEPTH));
    assign head  = store_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wp_reg] <= push_data;
        end
    end

endmodule

// File: sv/aim_front.sv
// ----------------------------------------------------------------------------
// aim_front
// Input side: takes requests, drops writes outside the store, queues the rest.
// ----------------------------------------------------------------------------
module aim_front #(
    parameter int MAX_WIDTH  = aim_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = aim_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [aim_pkg::COORD_W-1:0] s_col,
    input  logic [aim_pkg::COORD_W-1:0] s_row,
    input  logic [aim_pkg::PIX_W-1:0]   s_pixel_in,
    input  logic                        q_full,
    output logic                        q_push,
    output aim_pkg::item_t              q_item
);
    import aim_pkg::*;

    logic in_store;
    logic keep;

    assign in_store = (32'(s_col) < MAX_WIDTH) && (32'(s_row) < MAX_HEIGHT);
    assign keep     = (s_req_type == REQ_READ) || in_store;
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full && keep;

    always_comb begin
        q_item.wr  = (s_req_type == REQ_WRITE);
        q_item.x   = s_col;
        q_item.y   = s_row;
        q_item.pix = s_pixel_in;
    end

endmodule

// File: sv/aim_div.sv
// ----------------------------------------------------------------------------
// aim_div
// Pipelined restoring divider, one quotient bit per stage, with range check.
// ----------------------------------------------------------------------------
module aim_div #(
    parameter int QB = 8
) (
    input  logic                      aclk,
    input  logic [aim_pkg::MAG_W-1:0] num,
    input  logic [aim_pkg::MAG_W-1:0] den,
    output logic [QB-1:0]             quo,
    output logic                      ovf
);
    import aim_pkg::*;

    logic [MAG_W-1:0] rem_reg [QB+1];
    logic [MAG_W-1:0] dv_reg  [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             ov_reg  [QB+1];

    // quotient >= 2**QB lies outside any frame
    always_ff @(posedge aclk) begin
        rem_reg[0] <= num;
        dv_reg[0]  <= den;
        q_reg[0]   <= '0;
        ov_reg[0]  <= (num >= (den << QB));
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int BIT = QB - k;
        logic [MAG_W-1:0] trial;
        assign trial = dv_reg[k-1] << BIT;
        always_ff @(posedge aclk) begin
            dv_reg[k] <= dv_reg[k-1];
            ov_reg[k] <= ov_reg[k-1];
            if (rem_reg[k-1] >= trial) begin
                rem_reg[k] <= rem_reg[k-1] - trial;
                q_reg[k]   <= q_reg[k-1] | (QB'(1) << BIT);
            end else begin
                rem_reg[k] <= rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1];
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ov_reg[QB];

endmodule

// File: sv/aim_back.sv
// ----------------------------------------------------------------------------
// aim_back
// Execution side: inverse mapping pipeline, frame store, result queue.
// ----------------------------------------------------------------------------
module aim_back #(
    parameter int MAX_WIDTH  = aim_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = aim_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  aim_pkg::cfg_t             cfg,
    input  aim_pkg::item_t            q_head,
    input  logic                      q_empty,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [aim_pkg::PIX_W-1:0] m_pixel_out,
    output logic                      m_in_output,
    output logic                      m_source_hit,
    output logic                      m_singular
);
    import aim_pkg::*;

    localparam int QB    = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic          wr;
        logic [AW-1:0] addr;
        logic [PIX_W-1:0] pix;
        logic          io_ok;
        logic          sing;
        logic          negx;
        logic          negy;
    } line_t;

    // ---------------- config-derived terms, recomputed every cycle ----------
    logic signed [PROD_W-1:0]  pad_reg, pbc_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic [DIM_W-1:0]          w_eff_reg, h_eff_reg;
    logic signed [OUTSZ_W-1:0] ow_reg, oh_reg;
    logic signed [DET_W:0]     wd_prod, ha_prod;

    assign wd_prod = (DET_W+1)'($signed({1'b0, w_eff_reg})) * (DET_W+1)'($signed(cfg.d));
    assign ha_prod = (DET_W+1)'($signed({1'b0, h_eff_reg})) * (DET_W+1)'($signed(cfg.a));

    always_ff @(posedge aclk) begin
        pad_reg   <= PROD_W'($signed(cfg.a)) * PROD_W'($signed(cfg.d));
        pbc_reg   <= PROD_W'($signed(cfg.b)) * PROD_W'($signed(cfg.c));
        det_reg   <= DET_W'(pad_reg) - DET_W'(pbc_reg);
        w_eff_reg <= (32'(cfg.w) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : DIM_W'(cfg.w);
        h_eff_reg <= (32'(cfg.h) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg.h);
        ow_reg    <= OUTSZ_W'(wd_prod / 256);  // toward zero
        oh_reg    <= OUTSZ_W'(ha_prod / 256);
    end

    // ---------------- credit for result queue -------------------------------
    logic             oq_push, oq_pop, oq_empty, oq_full;
    result_t          oq_in, oq_head;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop_rd;

    assign q_pop  = !q_empty && (q_head.wr || (cnt_reg < CNT_W'(OQ_DEPTH)));
    assign pop_rd = q_pop && !q_head.wr;
    assign oq_pop = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (pop_rd && !oq_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (oq_pop && !pop_rd) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // ---------------- pipeline ----------------------------------------------
    logic          v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    item_t         it0_reg;

    logic signed [PROD_W-1:0] dx1_reg, by1_reg, cx1_reg, ay1_reg;
    logic signed [TDET_W-1:0] txd1_reg, tyd1_reg;
    logic [AW-1:0]            wa1_reg;
    logic                     io1_reg;
    logic                     wr1_reg;
    logic [PIX_W-1:0]         pix1_reg;

    logic signed [NUM_W-1:0] nx2_reg, ny2_reg;
    logic [MAG_W-1:0]        dm2_reg;
    logic                    dneg2_reg, sing2_reg, io2_reg, wr2_reg;
    logic [AW-1:0]           wa2_reg;
    logic [PIX_W-1:0]        pix2_reg;

    logic [MAG_W-1:0] nxm3_reg, nym3_reg, dm3_reg;
    line_t            ln3_reg;

    logic signed [PROD_W:0]  dxb, ayc;
    logic signed [NUM_W-1:0] dxb_ext, ayc_ext, txd_ext, tyd_ext;
    logic [DET_W-1:0]        det_mag;

    always_comb begin
        dxb     = (PROD_W+1)'(dx1_reg) - (PROD_W+1)'(by1_reg);
        ayc     = (PROD_W+1)'(ay1_reg) - (PROD_W+1)'(cx1_reg);
        dxb_ext = NUM_W'(dxb);
        ayc_ext = NUM_W'(ayc);
        txd_ext = NUM_W'(txd1_reg);
        tyd_ext = NUM_W'(tyd1_reg);
        det_mag = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            v0_reg  <= q_pop;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            it0_reg <= q_head;
        end
        // S1: products
        dx1_reg  <= PROD_W'($signed(cfg.d)) * PROD_W'($signed({1'b0, it0_reg.x}));
        by1_reg  <= PROD_W'($signed(cfg.b)) * PROD_W'($signed({1'b0, it0_reg.y}));
        cx1_reg  <= PROD_W'($signed(cfg.c)) * PROD_W'($signed({1'b0, it0_reg.x}));
        ay1_reg  <= PROD_W'($signed(cfg.a)) * PROD_W'($signed({1'b0, it0_reg.y}));
        txd1_reg <= TDET_W'($signed(cfg.tx)) * TDET_W'(det_reg);
        tyd1_reg <= TDET_W'($signed(cfg.ty)) * TDET_W'(det_reg);
        wa1_reg  <= AW'(32'(it0_reg.y) * MAX_WIDTH + 32'(it0_reg.x));
        io1_reg  <= ($signed({6'b0, it0_reg.x}) < ow_reg) &&
                    ($signed({6'b0, it0_reg.y}) < oh_reg);
        wr1_reg  <= it0_reg.wr;
        pix1_reg <= it0_reg.pix;
        // S2: numerators, |256*det|
        nx2_reg   <= (dxb_ext <<< 16) - txd_ext;
        ny2_reg   <= (ayc_ext <<< 16) - tyd_ext;
        dm2_reg   <= MAG_W'(det_mag) << 8;
        dneg2_reg <= det_reg[DET_W-1];
        sing2_reg <= (det_reg == '0);
        io2_reg   <= io1_reg;
        wr2_reg   <= wr1_reg;
        wa2_reg   <= wa1_reg;
        pix2_reg  <= pix1_reg;
        // S3: magnitudes and quotient signs
        nxm3_reg      <= nx2_reg[NUM_W-1] ? MAG_W'(-nx2_reg) : MAG_W'(nx2_reg);
        nym3_reg      <= ny2_reg[NUM_W-1] ? MAG_W'(-ny2_reg) : MAG_W'(ny2_reg);
        dm3_reg       <= dm2_reg;
        ln3_reg.wr    <= wr2_reg;
        ln3_reg.addr  <= wa2_reg;
        ln3_reg.pix   <= pix2_reg;
        ln3_reg.io_ok <= io2_reg;
        ln3_reg.sing  <= sing2_reg;
        ln3_reg.negx  <= nx2_reg[NUM_W-1] ^ dneg2_reg;
        ln3_reg.negy  <= ny2_reg[NUM_W-1] ^ dneg2_reg;
    end

    // ---------------- dividers and matching delay line ----------------------
    logic [QB-1:0] qx, qy;
    logic          ovx, ovy;

    aim_div #(.QB(QB)) u_divx (.aclk(aclk), .num(nxm3_reg), .den(dm3_reg),
                               .quo(qx), .ovf(ovx));
    aim_div #(.QB(QB)) u_divy (.aclk(aclk), .num(nym3_reg), .den(dm3_reg),
                               .quo(qy), .ovf(ovy));

    line_t ln_reg [QB+1];
    logic  lv_reg [QB+1];

    always_ff @(posedge aclk) begin
        ln_reg[0] <= ln3_reg;
        for (int i = 1; i <= QB; i++) begin
            ln_reg[i] <= ln_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QB; i++) begin
                lv_reg[i] <= 1'b0;
            end
        end else begin
            lv_reg[0] <= v3_reg;
            for (int i = 1; i <= QB; i++) begin
                lv_reg[i] <= lv_reg[i-1];
            end
        end
    end

    // ---------------- hit test, store access, result ------------------------
    line_t ld;
    logic  hitx, hity, hit;
    logic [AW-1:0] raddr;

    assign ld   = ln_reg[QB];
    // truncation toward zero: a negative quotient of magnitude zero is column 0
    assign hitx = !ovx && ((qx == '0) || !ld.negx) &&
                  ({{DIM_W{1'b0}}, qx} < (QB+DIM_W)'(w_eff_reg));
    assign hity = !ovy && ((qy == '0) || !ld.negy) &&
                  ({{DIM_W{1'b0}}, qy} < (QB+DIM_W)'(h_eff_reg));
    assign hit  = hitx && hity && !ld.sing;
    assign raddr = AW'(32'(qy) * MAX_WIDTH + 32'(qx));

    logic          wr4_reg, rd4_reg, io4_reg, hit4_reg, sing4_reg;
    logic [AW-1:0] addr4_reg;
    logic [PIX_W-1:0] pix4_reg;
    logic          wr5_reg, use5_reg, io5_reg, hit5_reg, sing5_reg;
    logic [PIX_W-1:0] rdata_reg;
    logic [PIX_W-1:0] fstore [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v4_reg <= lv_reg[QB];
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        wr4_reg   <= ld.wr;
        addr4_reg <= ld.wr ? ld.addr : raddr;
        pix4_reg  <= ld.pix;
        rd4_reg   <= !ld.wr && hit && ld.io_ok;
        io4_reg   <= ld.io_ok;
        hit4_reg  <= hit;
        sing4_reg <= ld.sing;
        wr5_reg   <= wr4_reg;
        use5_reg  <= rd4_reg;
        io5_reg   <= io4_reg;
        hit5_reg  <= hit4_reg;
        sing5_reg <= sing4_reg;
    end

    always_ff @(posedge aclk) begin
        if (v4_reg && wr4_reg) begin
            fstore[addr4_reg] <= pix4_reg;
        end
        if (v4_reg && rd4_reg) begin
            rdata_reg <= fstore[addr4_reg];
        end
    end

    assign oq_push     = v5_reg && !wr5_reg;
    assign oq_in.pix   = use5_reg ? rdata_reg : '0;
    assign oq_in.io_ok = io5_reg;
    assign oq_in.hit   = hit5_reg;
    assign oq_in.sing  = sing5_reg;

    aim_fifo #(.WIDTH($bits(result_t)), .DEPTH(OQ_DEPTH)) u_oq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (oq_push),
        .push_data (oq_in),
        .pop       (oq_pop),
        .head      (oq_head),
        .empty     (oq_empty),
        .full      (oq_full)
    );

    assign m_valid      = !oq_empty;
    assign m_pixel_out  = oq_head.pix;
    assign m_in_output  = oq_head.io_ok;
    assign m_source_hit = oq_head.hit;
    assign m_singular   = oq_head.sing;

    // ---------------- checks -------------------------------------------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(OQ_DEPTH))
        else $error("result credit count overran");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(oq_push && oq_full))
        else $error("result queue pushed while full");

    a_sing_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_push |-> !(oq_in.sing && oq_in.hit))
        else $error("hit reported on singular matrix");

    a_pix_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        (oq_push && !(oq_in.hit && oq_in.io_ok)) |-> (oq_in.pix == '0))
        else $error("nonzero pixel for uncovered request");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the inverse affine frame-store mapper. A corner of
// the store is filled first, then reads and writes run under a series of
// matrix, shift and size settings, mostly with random gaps and backpressure.
// Reads that would fetch a store entry not yet written are steered elsewhere.
// Every read result is checked against an in-bench prediction of the warp.
// ----------------------------------------------------------------------------
module tb;
    import aim_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int MAXH = MAX_HEIGHT_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = 1'b0;
    logic [COORD_W-1:0]    s_col = '0;
    logic [COORD_W-1:0]    s_row = '0;
    logic [PIX_W-1:0]      s_pixel_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIX_W-1:0]      m_pixel_out;
    logic                  m_in_output;
    logic                  m_source_hit;
    logic                  m_singular;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    affine_inverse_map_nearest u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_col        (s_col),
        .s_row        (s_row),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_in_output  (m_in_output),
        .m_source_hit (m_source_hit),
        .m_singular   (m_singular),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 aclk = ~aclk;

    // shadow of the block's registers and frame store
    logic [COEF_W-1:0]  sh_a = COEF_ONE_RST, sh_b = COEF_ZER_RST;
    logic [COEF_W-1:0]  sh_c = COEF_ZER_RST, sh_d = COEF_ONE_RST;
    logic [SHIFT_W-1:0] sh_tx = SHIFT_X_RST, sh_ty = SHIFT_Y_RST;
    logic [SIZE_W-1:0]  sh_w = SIZE_RST, sh_h = SIZE_RST;
    logic [PIX_W-1:0]   frame_mem [0:MAXW*MAXH-1];
    // entries that some queued write will have filled, in request order
    bit                 wr_mark [0:MAXW*MAXH-1];

    item_t   req_q [$];
    result_t pixel_q [$];
    logic [CFG_IDX_W+CFG_DATA_W-1:0] reg_q [$];

    int  errors = 0;
    bit  quiet = 1'b0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  cfg_gap = 0;

    // flags of a read; addr is the store entry fetched, or -1 when none
    function automatic result_t warp_map(logic [COORD_W-1:0] xi, logic [COORD_W-1:0] yi,
                                         output int addr);
        longint a, b, c, d, tx, ty, w, h, x, y, ow, oh, det, nx, ny, sx, sy;
        result_t r;
        a = $signed(sh_a);  b = $signed(sh_b);
        c = $signed(sh_c);  d = $signed(sh_d);
        tx = $signed(sh_tx); ty = $signed(sh_ty);
        w = sh_w; h = sh_h;
        if (w > MAXW) w = MAXW;
        if (h > MAXH) h = MAXH;
        x = xi; y = yi;
        r = '0;
        addr = -1;
        ow = (w * d) / 256;
        oh = (h * a) / 256;
        r.io_ok = (x < ow) && (y < oh);
        det = a * d - b * c;
        r.sing = (det == 0);
        if (!r.sing) begin
            nx = (d * x - b * y) * 65536 - tx * det;
            ny = (a * y - c * x) * 65536 - ty * det;
            sx = nx / (256 * det);
            sy = ny / (256 * det);
            r.hit = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
            if (r.hit && r.io_ok) addr = int'(sy * MAXW + sx);
        end
        return r;
    endfunction

    function automatic bit read_safe(int x, int y);
        result_t r;
        int fa;
        r = warp_map(COORD_W'(x), COORD_W'(y), fa);
        return (fa < 0) || wr_mark[fa];
    endfunction

    // request driver; predicts on acceptance
    always @(posedge aclk) begin
        item_t it;
        result_t r;
        int fa;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_WRITE) begin
                    if (s_col < MAXW && s_row < MAXH) frame_mem[s_row * MAXW + s_col] = s_pixel_in;
                end else begin
                    r = warp_map(s_col, s_row, fa);
                    if (fa >= 0) r.pix = frame_mem[fa];
                    pixel_q.push_back(r);
                end
            end
            if (!(s_valid && !s_ready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    src_gap <= $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    it = req_q.pop_front();
                    s_valid    <= 1'b1;
                    s_req_type <= it.wr;
                    s_col      <= it.x;
                    s_row      <= it.y;
                    s_pixel_in <= it.pix;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // register write driver
    always @(posedge aclk) begin
        logic [CFG_IDX_W+CFG_DATA_W-1:0] e;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_COEF_A:     sh_a  = cfg_data[COEF_W-1:0];
                    REG_COEF_B:     sh_b  = cfg_data[COEF_W-1:0];
                    REG_COEF_C:     sh_c  = cfg_data[COEF_W-1:0];
                    REG_COEF_D:     sh_d  = cfg_data[COEF_W-1:0];
                    REG_SHIFT_X:    sh_tx = cfg_data[SHIFT_W-1:0];
                    REG_SHIFT_Y:    sh_ty = cfg_data[SHIFT_W-1:0];
                    REG_SRC_WIDTH:  sh_w  = cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT: sh_h  = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (!(cfg_valid && !cfg_ready)) begin
                if (cfg_gap > 0) begin
                    cfg_gap <= cfg_gap - 1;
                    cfg_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 3) == 0) begin
                    cfg_gap <= $urandom_range(0, 12);
                    cfg_valid <= 1'b0;
                end else if (reg_q.size() > 0) begin
                    e = reg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= e[CFG_IDX_W+CFG_DATA_W-1:CFG_DATA_W];
                    cfg_data  <= e[CFG_DATA_W-1:0];
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected result pixel_out=%h", m_pixel_out);
                    errors++;
                end else begin
                    exp_r = pixel_q.pop_front();
                    if (m_pixel_out !== exp_r.pix) begin
                        $error("pixel_out exp %h got %h", exp_r.pix, m_pixel_out);
                        errors++;
                    end
                    if (m_in_output !== exp_r.io_ok) begin
                        $error("in_output exp %0b got %0b", exp_r.io_ok, m_in_output);
                        errors++;
                    end
                    if (m_source_hit !== exp_r.hit) begin
                        $error("source_hit exp %0b got %0b", exp_r.hit, m_source_hit);
                        errors++;
                    end
                    if (m_singular !== exp_r.sing) begin
                        $error("singular exp %0b got %0b", exp_r.sing, m_singular);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_req(req_t kind, int x, int y, int pix);
        item_t it;
        it.wr = kind;
        it.x = x;
        it.y = y;
        it.pix = pix;
        if (kind == REQ_WRITE && x < MAXW && y < MAXH) wr_mark[y * MAXW + x] = 1'b1;
        req_q.push_back(it);
    endtask

    // a read that would fetch an unwritten entry goes to a never-covered spot
    task automatic push_read(int x, int y);
        if (read_safe(x, y)) push_req(REQ_READ, x, y, 0);
        else push_req(REQ_READ, 2047, 2047, 0);
    endtask

    task automatic set_regs(int a, int b, int c, int d, int tx, int ty, int w, int h);
        logic [CFG_DATA_W-1:0] v [8];
        v[0] = a; v[1] = b; v[2] = c; v[3] = d;
        v[4] = tx; v[5] = ty; v[6] = w; v[7] = h;
        for (int i = 0; i < 8; i++) reg_q.push_back({cfg_reg_t'(i), v[i]});
        do @(posedge aclk); while (reg_q.size() > 0 || cfg_valid);
        // last write taken and shadow current
        repeat (2) @(posedge aclk);
    endtask

    // all requests taken, all results back, then a wait for the pipeline to empty
    task automatic drain();
        do @(posedge aclk); while (req_q.size() > 0 || s_valid || pixel_q.size() > 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_traffic(int n);
        int  x, y;
        bit  ok;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                push_req(REQ_WRITE, $urandom_range(0, 2047) % ($urandom_range(0, 1) ? 2048 : 256),
                         $urandom_range(0, 2047) % ($urandom_range(0, 1) ? 2048 : 256),
                         $urandom_range(0, 24'hFFFFFF));
            end else begin
                ok = 1'b0;
                x = 2047;
                y = 2047;
                for (int t = 0; t < 64 && !ok; t++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        x = $urandom_range(0, 2047);
                        y = $urandom_range(0, 2047);
                    end else if ($urandom_range(0, 1) == 0) begin
                        x = $urandom_range(0, 320);
                        y = $urandom_range(0, 320);
                    end else begin
                        x = $urandom_range(0, 40);
                        y = $urandom_range(0, 40);
                    end
                    ok = read_safe(x, y);
                end
                if (!ok) begin
                    x = 2047;
                    y = 2047;
                end
                push_req(REQ_READ, x, y, $urandom_range(0, 24'hFFFFFF));
            end
        end
    endtask

    task automatic near_regs();
        int a, d;
        a = $urandom_range(128, 640);
        d = $urandom_range(128, 640);
        if ($urandom_range(0, 5) == 0) a = -a;
        if ($urandom_range(0, 5) == 0) d = -d;
        set_regs(a, int'($urandom_range(0, 128)) - 64, int'($urandom_range(0, 128)) - 64, d,
                 int'($urandom_range(0, 16384)) - 8192, int'($urandom_range(0, 16384)) - 8192,
                 $urandom_range(1, 300), $urandom_range(1, 300));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // corner of the store near the origin
        for (int y = 0; y < 16; y++)
            for (int x = 0; x < 16; x++)
                push_req(REQ_WRITE, x, y, $urandom_range(0, 24'hFFFFFF));
        drain();

        // reset settings: +30 / -30 pixel shift
        push_req(REQ_WRITE, 0, 30, 24'hFFFFFF);
        push_req(REQ_WRITE, 2047, 2047, 24'h123456);
        push_req(REQ_WRITE, 255, 255, 24'h000000);
        push_read(30, 0);
        push_read(0, 0);
        push_read(255, 255);
        push_read(256, 0);
        push_read(2047, 2047);
        push_read(285, 225);
        random_traffic(60);
        drain();

        set_regs(256, 0, 0, 256, 0, 0, 256, 256);
        push_read(255, 255);
        push_read(0, 0);
        random_traffic(60);
        drain();

        // extremes, zero width, oversize height
        set_regs(-2048, 2047, -2048, 2047, -65536, 65535, 0, 511);
        push_read(0, 0);
        push_read(2047, 0);
        random_traffic(40);
        drain();

        set_regs(2047, -2048, 2047, -2048, 65535, -65536, 511, 0);
        random_traffic(30);
        drain();

        // singular matrix
        set_regs(512, 256, 1024, 512, 0, 0, 1, 1);
        push_read(0, 0);
        random_traffic(40);
        drain();

        // 2x upscale, uneven sizes
        set_regs(512, 0, 0, 512, 0, 0, 100, 200);
        push_read(199, 399);
        push_read(200, 399);
        push_read(15, 15);
        random_traffic(60);
        drain();

        for (int p = 0; p < 3; p++) begin
            near_regs();
            random_traffic(60);
            drain();
        end

        set_regs($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 131071),
                 $urandom_range(0, 131071), $urandom_range(0, 511), $urandom_range(0, 511));
        random_traffic(60);
        drain();

        quiet = 1'b1;
        near_regs();
        random_traffic(50);
        drain();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
